@@ hw/rtl/drbg_pkg.sv @@
// Shared types, codes and AES helper functions for the counter-mode DRBG block.
package drbg_pkg;

  localparam int MAX_BLOCKS_DEF = 64;
  localparam int WORD_W         = 64;
  localparam int LIMIT_W        = 49;
  localparam int BUF_WORDS      = 6;

  localparam logic [2:0] CMD_LOAD_ENT = 3'd0;
  localparam logic [2:0] CMD_LOAD_EXT = 3'd1;
  localparam logic [2:0] CMD_INST     = 3'd2;
  localparam logic [2:0] CMD_RESEED   = 3'd3;
  localparam logic [2:0] CMD_GEN      = 3'd4;

  localparam logic [1:0] ST_BLOCK  = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_RESEED = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1) << 48;

  typedef enum logic [3:0] {
    S_IDLE, S_UPD_BUMP, S_UPD_GO, S_UPD_WAIT, S_GEN_BUMP, S_GEN_GO,
    S_GEN_WAIT, S_EMIT_BLK, S_FIN, S_EMIT_LAST
  } drbg_state_t;

  typedef enum logic [1:0] {A_IDLE, A_SUB, A_MIX} aes_state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the state sits at bits [127-8i -: 8].
  function automatic logic [127:0] shift_rows(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[127-8*(i+4*c) -: 8] = s[127-8*(i+4*((c+i)%4)) -: 8];
      end
    end
    shift_rows = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127-32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119-32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111-32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103-32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix_columns = t;
  endfunction

endpackage

@@ hw/rtl/drbg_aes.sv @@
// Byte-serial AES-256 encryption core with on-the-fly key expansion.
module drbg_aes (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [255:0] key,
  input  logic [127:0] blk,
  output logic         done,
  output logic [127:0] result
);
  import drbg_pkg::*;

  aes_state_t    state_r, state_nxt;
  logic [127:0]  s_r;
  logic [255:0]  win_r;
  logic [31:0]   tw_r;
  logic [3:0]    rnd_r;
  logic [3:0]    cnt_r;
  logic          done_r;
  logic [1:0]    ksel;
  logic [31:0]   tfun, nw0, nw1, nw2, nw3;
  logic [127:0]  rk, mixed;
  logic [7:0]    rcon;

  // Bytes of the last window word go through the key S-box while the substitution
  // counter is below four; even rounds rotate the word first.
  assign ksel = rnd_r[0] ? cnt_r[1:0] : (cnt_r[1:0] + 2'd1);
  assign rcon = 8'h01 << (rnd_r[3:1] - 3'd1);
  assign tfun = rnd_r[0] ? tw_r : (tw_r ^ {rcon, 24'h0});
  assign nw0  = win_r[255:224] ^ tfun;
  assign nw1  = win_r[223:192] ^ nw0;
  assign nw2  = win_r[191:160] ^ nw1;
  assign nw3  = win_r[159:128] ^ nw2;
  assign rk   = (rnd_r == 4'd1) ? win_r[127:0] : {nw0, nw1, nw2, nw3};
  assign mixed = (rnd_r == 4'd14) ? shift_rows(s_r) : mix_columns(shift_rows(s_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      A_IDLE: if (start) state_nxt = A_SUB;
      A_SUB:  if (cnt_r == 4'd15) state_nxt = A_MIX;
      A_MIX:  state_nxt = (rnd_r == 4'd14) ? A_IDLE : A_SUB;
      default: state_nxt = A_IDLE;
    endcase
  end

  always_comb begin
    done   = done_r;
    result = s_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
      rnd_r   <= 4'd1;
      cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == A_MIX) && (rnd_r == 4'd14);
      unique case (state_r)
        A_IDLE: begin
          if (start) begin
            rnd_r <= 4'd1;
            cnt_r <= 4'd0;
          end
        end
        A_SUB: cnt_r <= cnt_r + 4'd1;
        A_MIX: begin
          cnt_r <= 4'd0;
          rnd_r <= rnd_r + 4'd1;
        end
        default: cnt_r <= 4'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      A_IDLE: begin
        if (start) begin
          s_r   <= blk ^ key[255:128];
          win_r <= key;
        end
      end
      A_SUB: begin
        s_r <= {s_r[119:0], SBOX[s_r[127:120]]};
        if (cnt_r < 4'd4) begin
          tw_r <= {tw_r[23:0], SBOX[win_r[31-8*ksel -: 8]]};
        end
      end
      A_MIX: begin
        s_r <= mixed ^ rk;
        if (rnd_r != 4'd1) win_r <= {win_r[127:0], nw0, nw1, nw2, nw3};
      end
      default: s_r <= s_r;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(state_r) == A_MIX && $past(rnd_r) == 4'd14)
    else $error("aes done without final round");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == A_SUB |-> rnd_r >= 4'd1 && rnd_r <= 4'd14)
    else $error("aes round out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == A_SUB && cnt_r == 4'd15) |=> state_r == A_MIX)
    else $error("aes mix step skipped");

endmodule

@@ hw/rtl/aes256_ctr_drbg_no_df.sv @@
// Top level of the AES-256 counter-mode DRBG without derivation function.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  in_     | input     | in_valid / in_stall   | cmd, word_index, data_word, ...
//  out_    | output    | out_valid / out_stall | status, block_high/low, last
//  cfg_    | input     | cfg_wr_en             | cfg_wr_data (reseed limit)
//
// Load requests are taken in the idle state and write one buffer word. Every
// AES-256 encryption runs in the byte-serial core after a counter bump and
// a start strobe. An update costs three encryptions and every block one more
// output slot. A generate request with additional input runs a pre-update
// before its blocks; an accepted generate request ends with a final update.
// Reset is synchronous and active low; it clears key, counter, buffers and
// the reseed counter, and sets the reseed limit to 2^48. The input side is
// stalled while a consuming request is in progress; the output register holds
// its result while out_stall is high and the sequencer waits for it.
module aes256_ctr_drbg_no_df #(
  parameter int MAX_BLOCKS = drbg_pkg::MAX_BLOCKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_cmd,
  input  logic [2:0]                   in_word_index,
  input  logic [drbg_pkg::WORD_W-1:0]  in_data_word,
  input  logic [6:0]                   in_block_count,
  input  logic                         in_has_additional,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic [drbg_pkg::WORD_W-1:0]  out_block_high,
  output logic [drbg_pkg::WORD_W-1:0]  out_block_low,
  output logic                         out_last,
  input  logic                         cfg_wr_en,
  input  logic [drbg_pkg::LIMIT_W-1:0] cfg_wr_data
);
  import drbg_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  drbg_state_t          state_r, state_nxt;
  logic [LIMIT_W-1:0]   limit_r;
  logic [LIMIT_W-1:0]   gen_cnt_r;
  logic [255:0]         key_r;
  logic [127:0]         v_r;
  logic [WORD_W-1:0]    ent_r [BUF_WORDS];
  logic [WORD_W-1:0]    ext_r [BUF_WORDS];
  logic [127:0]         tmp0_r, tmp1_r;
  logic [1:0]           upd_i_r;
  logic                 mode_ent_r, mode_ext_r;
  logic                 post_r, is_gen_r;
  logic [CNT_W-1:0]     n_r, bidx_r;
  logic [1:0]           last_code_r;

  logic                 out_valid_r, out_last_r;
  logic [1:0]           out_status_r;
  logic [WORD_W-1:0]    out_hi_r, out_lo_r;

  logic                 accept, out_free, out_load, aes_start, aes_done, refuse;
  logic [127:0]         aes_res, pe, px, pv, upd_word;
  logic [6:0]           sat_cnt;

  drbg_aes u_aes (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (aes_start),
    .key    (key_r),
    .blk    (v_r),
    .done   (aes_done),
    .result (aes_res)
  );

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  // The output register takes a new result in this cycle.
  assign out_load = ((state_r == S_EMIT_BLK) || (state_r == S_EMIT_LAST)) && out_free;
  assign refuse   = gen_cnt_r > limit_r;
  assign sat_cnt  = (in_block_count > 7'(MAX_BLOCKS)) ? 7'(MAX_BLOCKS) : in_block_count;

  // Provided data for the update block now being encrypted.
  always_comb begin
    case (upd_i_r)
      2'd0:    begin pe = {ent_r[0], ent_r[1]}; px = {ext_r[0], ext_r[1]}; end
      2'd1:    begin pe = {ent_r[2], ent_r[3]}; px = {ext_r[2], ext_r[3]}; end
      default: begin pe = {ent_r[4], ent_r[5]}; px = {ext_r[4], ext_r[5]}; end
    endcase
    pv = (mode_ent_r ? pe : 128'h0) ^ (mode_ext_r ? px : 128'h0);
    upd_word = aes_res ^ pv;
  end

  // Next-state logic of the command sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_INST, CMD_RESEED: state_nxt = S_UPD_BUMP;
            CMD_GEN: begin
              if (refuse) state_nxt = S_EMIT_LAST;
              else if (in_has_additional) state_nxt = S_UPD_BUMP;
              else if (sat_cnt == 7'd0) state_nxt = S_UPD_BUMP;
              else state_nxt = S_GEN_BUMP;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_UPD_BUMP: state_nxt = S_UPD_GO;
      S_UPD_GO:   state_nxt = S_UPD_WAIT;
      S_UPD_WAIT: begin
        if (aes_done) begin
          if (upd_i_r != 2'd2) state_nxt = S_UPD_BUMP;
          else if (post_r) state_nxt = S_FIN;
          else if (n_r == '0) state_nxt = S_UPD_BUMP;
          else state_nxt = S_GEN_BUMP;
        end
      end
      S_GEN_BUMP: state_nxt = S_GEN_GO;
      S_GEN_GO:   state_nxt = S_GEN_WAIT;
      S_GEN_WAIT: if (aes_done) state_nxt = S_EMIT_BLK;
      S_EMIT_BLK: begin
        if (out_free) state_nxt = (bidx_r == n_r - 1'b1) ? S_UPD_BUMP : S_GEN_BUMP;
      end
      S_FIN: state_nxt = (is_gen_r && n_r != '0) ? S_IDLE : S_EMIT_LAST;
      S_EMIT_LAST: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshake outputs and the core start strobe.
  always_comb begin
    in_stall  = (state_r != S_IDLE);
    aes_start = (state_r == S_UPD_GO) || (state_r == S_GEN_GO);
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_block_high = out_hi_r;
  assign out_block_low  = out_lo_r;
  assign out_last       = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= LIMIT_RESET;
      gen_cnt_r   <= '0;
      key_r       <= '0;
      v_r         <= '0;
      out_valid_r <= 1'b0;
      upd_i_r     <= 2'd0;
      for (int i = 0; i < BUF_WORDS; i++) begin
        ent_r[i] <= '0;
        ext_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      if (out_valid_r && !out_stall && !out_load) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            upd_i_r <= 2'd0;
            case (in_cmd)
              CMD_LOAD_ENT: begin
                if (in_word_index < 3'(BUF_WORDS)) ent_r[in_word_index] <= in_data_word;
              end
              CMD_LOAD_EXT: begin
                if (in_word_index < 3'(BUF_WORDS)) ext_r[in_word_index] <= in_data_word;
              end
              CMD_INST: begin
                key_r <= '0;
                v_r   <= '0;
              end
              CMD_GEN: begin
                if (refuse) begin
                  for (int i = 0; i < BUF_WORDS; i++) begin
                    ent_r[i] <= '0;
                    ext_r[i] <= '0;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_UPD_BUMP, S_GEN_BUMP: v_r <= v_r + 128'd1;
        S_UPD_WAIT: begin
          if (aes_done) begin
            if (upd_i_r == 2'd2) begin
              key_r   <= {tmp0_r, tmp1_r};
              v_r     <= upd_word;
              upd_i_r <= 2'd0;
            end else begin
              upd_i_r <= upd_i_r + 2'd1;
            end
          end
        end
        S_EMIT_BLK: begin
          if (out_free) out_valid_r <= 1'b1;
        end
        S_FIN: begin
          if (is_gen_r) begin
            if (gen_cnt_r != '1) gen_cnt_r <= gen_cnt_r + 1'b1;
          end else begin
            gen_cnt_r <= LIMIT_W'(1);
          end
          for (int i = 0; i < BUF_WORDS; i++) begin
            ent_r[i] <= '0;
            ext_r[i] <= '0;
          end
        end
        S_EMIT_LAST: begin
          if (out_free) out_valid_r <= 1'b1;
        end
        default: upd_i_r <= upd_i_r;
      endcase
    end
  end

  // Request bookkeeping and output payload; no reset needed.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          is_gen_r    <= (in_cmd == CMD_GEN);
          n_r         <= CNT_W'(sat_cnt);
          bidx_r      <= '0;
          last_code_r <= (in_cmd == CMD_GEN && refuse) ? ST_RESEED : ST_DONE;
          if (in_cmd == CMD_GEN) begin
            mode_ent_r <= 1'b0;
            mode_ext_r <= in_has_additional;
            post_r     <= !in_has_additional;
          end else begin
            mode_ent_r <= 1'b1;
            mode_ext_r <= 1'b1;
            post_r     <= 1'b1;
          end
        end
      end
      S_UPD_WAIT: begin
        if (aes_done) begin
          if (upd_i_r == 2'd0) tmp0_r <= upd_word;
          if (upd_i_r == 2'd1) tmp1_r <= upd_word;
          // After the pre-update the final update reuses the extra words.
          if (upd_i_r == 2'd2) post_r <= 1'b1;
        end
      end
      S_EMIT_BLK: begin
        if (out_free) begin
          out_status_r <= ST_BLOCK;
          out_hi_r     <= aes_res[127:64];
          out_lo_r     <= aes_res[63:0];
          out_last_r   <= (bidx_r == n_r - 1'b1);
          bidx_r       <= bidx_r + 1'b1;
          post_r       <= 1'b1;
        end
      end
      S_EMIT_LAST: begin
        if (out_free) begin
          out_status_r <= last_code_r;
          out_hi_r     <= '0;
          out_lo_r     <= '0;
          out_last_r   <= 1'b1;
        end
      end
      default: bidx_r <= bidx_r;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    aes_done |-> (state_r == S_UPD_WAIT || state_r == S_GEN_WAIT))
    else $error("cipher result arrived while the sequencer was not waiting");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_BLOCK) |-> out_last_r)
    else $error("status result not marked last");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GEN_BUMP |-> n_r != '0 && bidx_r < n_r)
    else $error("block index out of range");

endmodule
